>>> rtl/core/tcw_pkg.sv
// Package with the shared types, codes and sizes of the text console character writer.
package tcw_pkg;

  // Default grid and tab sizes.
  localparam int COLUMNS_DEFAULT  = 80;
  localparam int ROWS_DEFAULT     = 25;
  localparam int TAB_STOP_DEFAULT = 2;

  // Fixed widths, sized for the largest grid and tab stop supported.
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ROW_BASE_W = 12;
  localparam int ADDR_W     = 11;
  localparam int VALUE_W    = 16;
  localparam int PHASE_W    = 3;
  localparam int TAB_CNT_W  = 4;
  localparam int CFG_IDX_W  = 1;

  // Character codes with a special meaning.
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd1;

  // Reset values of the colour registers.
  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

  // Kind of work that one character asks of the back end.
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_LF,
    OP_CR,
    OP_BS,
    OP_TAB
  } op_kind_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] code;
  } op_t;

endpackage

>>> rtl/core/tcw_front.sv
// Front end: accepts characters and classifies them into operations.
module tcw_front (
  input  logic                       push,
  output logic                       full,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  output logic                       op_push,
  output tcw_pkg::op_t               op,
  input  logic                       op_full
);

  // A character is taken whenever the queue has room.
  assign full    = op_full;
  assign op_push = push && !op_full;

  // Sort the character into its operation kind.
  always_comb begin
    op.code = char_code;
    case (char_code)
      tcw_pkg::CODE_LF:  op.kind = tcw_pkg::OP_LF;
      tcw_pkg::CODE_CR:  op.kind = tcw_pkg::OP_CR;
      tcw_pkg::CODE_BS:  op.kind = tcw_pkg::OP_BS;
      tcw_pkg::CODE_TAB: op.kind = tcw_pkg::OP_TAB;
      default:           op.kind = tcw_pkg::OP_PRINT;
    endcase
  end

endmodule

>>> rtl/core/tcw_op_queue.sv
// Two-entry queue of classified operations between the front and back ends.
module tcw_op_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  tcw_pkg::op_t wr_op,
  output logic         full,
  input  logic         rd_en,
  output tcw_pkg::op_t rd_op,
  output logic         not_empty
);

  tcw_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_op     = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_op;
    end
  end

endmodule

>>> rtl/core/tcw_back.sv
// Back end: keeps the cursor and colours and produces the cell writes.
module tcw_back #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                          op_valid,
  input  tcw_pkg::op_t                  op,
  output logic                          op_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [tcw_pkg::ADDR_W-1:0]    cell_address,
  output logic [tcw_pkg::VALUE_W-1:0]   cell_value,
  output logic                          last
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int BASE_W = tcw_pkg::ROW_BASE_W;
  localparam int PH_W   = tcw_pkg::PHASE_W;
  localparam int TC_W   = tcw_pkg::TAB_CNT_W;

  logic [tcw_pkg::COLOR_W-1:0] foreground;
  logic [tcw_pkg::COLOR_W-1:0] background;
  logic [COL_W-1:0]            column, column_next;
  logic [ROW_W-1:0]            row, row_next;
  logic [BASE_W-1:0]           row_base, row_base_next;
  logic [PH_W-1:0]             phase, phase_next;
  logic                        tab_active, tab_active_next;
  logic [TC_W-1:0]             tab_left, tab_left_next;
  logic                        out_valid;

  logic                        col_wrap, row_wrap;
  logic [COL_W-1:0]            adv_column;
  logic [PH_W-1:0]             adv_phase;
  logic [ROW_W-1:0]            lf_row;
  logic [BASE_W-1:0]           lf_base;
  logic                        slot_free;
  logic                        do_write;
  logic [COL_W-1:0]            wr_column;
  logic [tcw_pkg::CHAR_W-1:0]  wr_char;
  logic                        wr_last;
  logic [TC_W-1:0]             tab_count;
  logic [BASE_W-1:0]           addr_sum;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;

  // Colour registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      foreground <= tcw_pkg::FOREGROUND_RESET;
      background <= tcw_pkg::BACKGROUND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tcw_pkg::REG_FOREGROUND: foreground <= cfg_data;
        tcw_pkg::REG_BACKGROUND: background <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cursor movement shared by the operations.
  always_comb begin
    col_wrap = (column == COL_W'(COLUMNS - 1));
    row_wrap = (row == ROW_W'(ROWS - 1));
    lf_row   = row_wrap ? '0 : row + ROW_W'(1);
    lf_base  = row_wrap ? '0 : row_base + BASE_W'(COLUMNS);
    if (col_wrap) begin
      adv_column = '0;
      adv_phase  = '0;
    end else begin
      adv_column = column + COL_W'(1);
      adv_phase  = (phase == PH_W'(TAB_STOP - 1)) ? '0 : phase + PH_W'(1);
    end
    tab_count = TC_W'(TAB_STOP) - TC_W'(phase);
  end

  // Operation sequencing: decide the cursor update and any cell write.
  always_comb begin
    column_next     = column;
    row_next        = row;
    row_base_next   = row_base;
    phase_next      = phase;
    tab_active_next = tab_active;
    tab_left_next   = tab_left;
    op_pop          = 1'b0;
    do_write        = 1'b0;
    wr_column       = column;
    wr_char         = tcw_pkg::CODE_SPACE;
    wr_last         = 1'b1;
    if (op_valid) begin
      case (op.kind)
        tcw_pkg::OP_LF: begin
          op_pop        = 1'b1;
          column_next   = '0;
          phase_next    = '0;
          row_next      = lf_row;
          row_base_next = lf_base;
        end
        tcw_pkg::OP_CR: begin
          op_pop      = 1'b1;
          column_next = '0;
          phase_next  = '0;
        end
        tcw_pkg::OP_BS: begin
          if (column == '0) begin
            op_pop = 1'b1;
          end else if (slot_free) begin
            op_pop      = 1'b1;
            do_write    = 1'b1;
            wr_column   = column - COL_W'(1);
            column_next = column - COL_W'(1);
            phase_next  = (phase == '0) ? PH_W'(TAB_STOP - 1) : phase - PH_W'(1);
          end
        end
        tcw_pkg::OP_TAB: begin
          if (slot_free) begin
            do_write    = 1'b1;
            column_next = adv_column;
            phase_next  = adv_phase;
            if (col_wrap) begin
              row_next      = lf_row;
              row_base_next = lf_base;
            end
            if (tab_active) begin
              wr_last       = (tab_left == TC_W'(1));
              tab_left_next = tab_left - TC_W'(1);
            end else begin
              wr_last       = (tab_count == TC_W'(1));
              tab_left_next = tab_count - TC_W'(1);
            end
            tab_active_next = !wr_last;
            op_pop          = wr_last;
          end
        end
        default: begin
          if (slot_free) begin
            op_pop      = 1'b1;
            do_write    = 1'b1;
            wr_char     = op.code;
            column_next = adv_column;
            phase_next  = adv_phase;
            if (col_wrap) begin
              row_next      = lf_row;
              row_base_next = lf_base;
            end
          end
        end
      endcase
    end
    addr_sum = row_base + BASE_W'(wr_column);
  end

  // Cursor and tab state.
  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      row_base   <= '0;
      phase      <= '0;
      tab_active <= 1'b0;
      tab_left   <= '0;
    end else begin
      column     <= column_next;
      row        <= row_next;
      row_base   <= row_base_next;
      phase      <= phase_next;
      tab_active <= tab_active_next;
      tab_left   <= tab_left_next;
    end
  end

  // Output register holding the oldest waiting cell write.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_write) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      cell_address <= addr_sum[tcw_pkg::ADDR_W-1:0];
      cell_value   <= {background, foreground, wr_char};
      last         <= wr_last;
    end
  end

endmodule

>>> rtl/core/text_console_char_writer_core.sv
// Text console character writer: classifies characters and turns them into cell writes.
// The block takes one character code per clock cycle while the queue has room, and
// keeps a cursor in a grid of ROWS by COLUMNS cells. Printable codes, tab and backspace
// (but for a backspace at column zero) produce writes of a 16-bit cell word (character
// in the low byte, background and foreground colour in the high byte) to cell address
// row * COLUMNS + column; line feed and carriage return only move the cursor. A front
// end classifies each character into a two-entry queue, and a back end with a one-entry
// output register carries it out, so input is taken while a result still waits. A tab
// writes TAB_STOP minus the column modulo TAB_STOP spaces, one at a time, and the queue
// fills behind it. A result passes through the queue and the output register, and the
// last write of a character is flagged by last.
module text_console_char_writer_core #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  output logic                          empty,
  input  logic                          pop,
  output logic [tcw_pkg::ADDR_W-1:0]    cell_address,
  output logic [tcw_pkg::VALUE_W-1:0]   cell_value,
  output logic                          last
);

  logic         op_push;
  tcw_pkg::op_t front_op;
  logic         op_full;
  logic         op_pop;
  tcw_pkg::op_t head_op;
  logic         head_valid;

  // Classification of incoming characters.
  tcw_front u_front (
    .push      (push),
    .full      (full),
    .char_code (char_code),
    .op_push   (op_push),
    .op        (front_op),
    .op_full   (op_full)
  );

  // Decoupling queue.
  tcw_op_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (op_push),
    .wr_op     (front_op),
    .full      (op_full),
    .rd_en     (op_pop),
    .rd_op     (head_op),
    .not_empty (head_valid)
  );

  // Cursor keeping and cell write generation.
  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op_valid     (head_valid),
    .op           (head_op),
    .op_pop       (op_pop),
    .empty        (empty),
    .pop          (pop),
    .cell_address (cell_address),
    .cell_value   (cell_value),
    .last         (last)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the text console character writer core.
`timescale 1ns / 100ps

module tb_top;

  localparam int COLUMNS       = tcw_pkg::COLUMNS_DEFAULT;
  localparam int ROWS          = tcw_pkg::ROWS_DEFAULT;
  localparam int TAB_STOP      = tcw_pkg::TAB_STOP_DEFAULT;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHUNK_ITEMS   = 230;
  localparam int REPORT_LIMIT  = 10;

  // One cell write as it leaves the block.
  typedef struct packed {
    logic [tcw_pkg::ADDR_W-1:0]  addr;
    logic [tcw_pkg::VALUE_W-1:0] value;
    logic                        last;
  } cell_write_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = tcw_pkg::REG_FOREGROUND;
  logic [tcw_pkg::COLOR_W-1:0]   cfg_data = '0;
  logic                          push = 1'b0;
  logic                          full;
  logic [tcw_pkg::CHAR_W-1:0]    char_code = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [tcw_pkg::ADDR_W-1:0]    cell_address;
  logic [tcw_pkg::VALUE_W-1:0]   cell_value;
  logic                          last;

  // Characters waiting to be pushed, and the writes they are expected to cause.
  logic [tcw_pkg::CHAR_W-1:0] pending_chars[$];
  cell_write_t                expected_writes[$];

  // Predicted cursor and colour registers.
  logic [tcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tcw_pkg::COL_W-1:0]   cursor_col;
  logic [tcw_pkg::COLOR_W-1:0] fg_colour;
  logic [tcw_pkg::COLOR_W-1:0] bg_colour;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  push_taken = 1'b0;
  int  items_queued = 0;
  int  items_accepted = 0;
  int  writes_checked = 0;
  int  mismatch_count = 0;
  int  colour_writes = 0;
  int  tabs_seen = 0;
  int  backspaces_seen = 0;
  int  line_feeds_seen = 0;

  text_console_char_writer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .char_code    (char_code),
    .empty        (empty),
    .pop          (pop),
    .cell_address (cell_address),
    .cell_value   (cell_value),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Moves the predicted cursor down one row, wrapping to the top.
  task automatic advance_row();
    if (int'(cursor_row) >= ROWS - 1) begin
      cursor_row = '0;
    end else begin
      cursor_row = cursor_row + 1'b1;
    end
  endtask

  // Records the write at the cursor for one printed character and advances the cursor.
  task automatic print_at_cursor(input logic [tcw_pkg::CHAR_W-1:0] ch);
    cell_write_t w;
    w.addr  = tcw_pkg::ADDR_W'(int'(cursor_row) * COLUMNS + int'(cursor_col));
    w.value = {bg_colour, fg_colour, ch};
    w.last  = 1'b0;
    expected_writes.push_back(w);
    if (int'(cursor_col) >= COLUMNS - 1) begin
      cursor_col = '0;
      advance_row();
    end else begin
      cursor_col = cursor_col + 1'b1;
    end
  endtask

  // Works out the cell writes caused by one accepted character.
  task automatic predict_char_writes(input logic [tcw_pkg::CHAR_W-1:0] code);
    int          size_at_start;
    int          spaces;
    cell_write_t w;
    size_at_start = expected_writes.size();
    case (code)
      tcw_pkg::CODE_LF: begin
        line_feeds_seen++;
        cursor_col = '0;
        advance_row();
      end
      tcw_pkg::CODE_CR: begin
        cursor_col = '0;
      end
      tcw_pkg::CODE_BS: begin
        backspaces_seen++;
        if (cursor_col != '0) begin
          cursor_col = cursor_col - 1'b1;
          w.addr  = tcw_pkg::ADDR_W'(int'(cursor_row) * COLUMNS + int'(cursor_col));
          w.value = {bg_colour, fg_colour, tcw_pkg::CODE_SPACE};
          w.last  = 1'b0;
          expected_writes.push_back(w);
        end
      end
      tcw_pkg::CODE_TAB: begin
        tabs_seen++;
        spaces = TAB_STOP - (int'(cursor_col) % TAB_STOP);
        repeat (spaces) print_at_cursor(tcw_pkg::CODE_SPACE);
      end
      default: begin
        print_at_cursor(code);
      end
    endcase
    // The newest write of this character carries the last flag.
    if (expected_writes.size() > size_at_start) begin
      w = expected_writes.pop_back();
      w.last = 1'b1;
      expected_writes.push_back(w);
    end
  endtask

  // Driver: pushes pending characters and pops results at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || push_taken) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push      <= 1'b1;
          char_code <= pending_chars.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks result transactions, then predicts from input and register transactions.
  always @(posedge clk) begin
    cell_write_t want;
    if (rst) begin
      push_taken = 1'b0;
      cursor_row = '0;
      cursor_col = '0;
      fg_colour  = tcw_pkg::FOREGROUND_RESET;
      bg_colour  = tcw_pkg::BACKGROUND_RESET;
    end else begin
      if (pop && !empty) begin
        writes_checked++;
        if (expected_writes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: unexpected cell write addr=%0d value=%h last=%b",
                     $realtime, cell_address, cell_value, last);
          end
        end else begin
          want = expected_writes.pop_front();
          if (cell_address !== want.addr || cell_value !== want.value
              || last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("ERROR @%0t: cell write addr=%0d/%0d value=%h/%h last=%b/%b",
                       $realtime, cell_address, want.addr, cell_value, want.value,
                       last, want.last);
              $display("  (actual/expected shown for each field)");
            end
          end
        end
      end
      if (cfg_write) begin
        colour_writes++;
        if (cfg_index == tcw_pkg::REG_FOREGROUND) begin
          fg_colour = cfg_data;
        end else if (cfg_index == tcw_pkg::REG_BACKGROUND) begin
          bg_colour = cfg_data;
        end
      end
      push_taken = push && !full;
      if (push_taken) begin
        items_accepted++;
        predict_char_writes(char_code);
      end
    end
  end

  // Adds one character to the pending queue.
  task automatic queue_char(input logic [tcw_pkg::CHAR_W-1:0] code);
    pending_chars.push_back(code);
    items_queued++;
  endtask

  // Writes one colour register while the block is idle.
  task automatic write_colour(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tcw_pkg::COLOR_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Holds off the sender until every character is taken and every write has arrived.
  task automatic wait_until_idle();
    while (items_accepted != items_queued || expected_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Queues one line of text: random content with some tabs and backspaces, then an ending.
  task automatic queue_line();
    int len;
    int roll;
    len = ($urandom_range(7) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 30);
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        queue_char(tcw_pkg::CODE_TAB);
      end else if (roll < 12) begin
        queue_char(tcw_pkg::CODE_BS);
      end else begin
        queue_char(tcw_pkg::CHAR_W'($urandom_range(255)));
      end
    end
    roll = $urandom_range(9);
    if (roll < 6) begin
      queue_char(tcw_pkg::CODE_LF);
    end else if (roll < 8) begin
      queue_char(tcw_pkg::CODE_CR);
      queue_char(tcw_pkg::CODE_LF);
    end else begin
      queue_char(tcw_pkg::CODE_CR);
    end
  endtask

  // Run limit.
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    logic [tcw_pkg::COLOR_W-1:0] fg_plan[6];
    logic [tcw_pkg::COLOR_W-1:0] bg_plan[6];
    int                          start;
    fg_plan = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd0};
    bg_plan = '{4'd0, 4'd15, 4'd15, 4'd0, 4'd0, 4'd0};
    fg_plan[4] = tcw_pkg::COLOR_W'($urandom_range(15));
    bg_plan[4] = tcw_pkg::COLOR_W'($urandom_range(15));
    fg_plan[5] = tcw_pkg::COLOR_W'($urandom_range(15));
    bg_plan[5] = tcw_pkg::COLOR_W'($urandom_range(15));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed characters with the reset colours.
    @(posedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 61;
    queue_char(8'h41);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h55);
    queue_char(8'hAA);
    queue_char(tcw_pkg::CODE_BS);
    queue_char(tcw_pkg::CODE_TAB);
    queue_char(8'h7E);
    queue_char(tcw_pkg::CODE_TAB);
    queue_char(tcw_pkg::CODE_CR);
    queue_char(tcw_pkg::CODE_BS);
    queue_char(tcw_pkg::CODE_TAB);
    queue_char(tcw_pkg::CODE_LF);
    queue_char(tcw_pkg::CODE_BS);
    queue_char(tcw_pkg::CODE_SPACE);
    queue_char(tcw_pkg::CODE_LF);
    queue_char(tcw_pkg::CODE_CR);
    queue_char(8'h80);
    queue_char(8'h01);
    wait_until_idle();

    // Random text in chunks, each with its own colours; pairs of chunks share an idling pattern.
    for (int chunk = 0; chunk < 6; chunk++) begin
      write_colour(tcw_pkg::REG_FOREGROUND, fg_plan[chunk]);
      write_colour(tcw_pkg::REG_BACKGROUND, bg_plan[chunk]);
      @(posedge clk);
      if (chunk < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end else if (chunk < 4) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      start = items_queued;
      while (items_queued - start < CHUNK_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 6)) queue_char(tcw_pkg::CHAR_W'($urandom_range(255)));
        end else begin
          queue_line();
        end
      end
      wait_until_idle();
    end

    $display("Covered %0d characters (%0d tabs, %0d backspaces, %0d line feeds).",
             items_accepted, tabs_seen, backspaces_seen, line_feeds_seen);
    $display("Checked %0d cell writes over %0d colour register writes.",
             writes_checked, colour_writes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
